>>> hdl/peak_normalize_scale_core_assert.svh
// assertion macros shared by the peak normalization core
// no dependencies; included by modules that carry concurrent checks
`ifndef PEAK_NORMALIZE_SCALE_CORE_ASSERT_SVH
`define PEAK_NORMALIZE_SCALE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication under synchronous active-low reset
`define PNS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication under synchronous active-low reset
`define PNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PNS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/pns_pkg.sv
// shared types, constants and state encodings of the peak normalization core
// no dependencies
`timescale 1ns / 1ps
package pns_pkg;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int SCALE_W  = 8;
    localparam int RESULT_W = 9;
    localparam int QUOT_W   = 9;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;
    localparam int NUM_W    = PROD_W + 1;
    localparam int DIV_W    = SAMPLE_W + 1;
    localparam int STEP_W   = 4;

    // frame size default
    localparam int DEFAULT_FRAME_POINTS = 64;

    // configuration register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_SCALE = REG_IDX_W'(0);
    localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RESET = SCALE_W'(10);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       sample_invalid;
        logic                       frame_last;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] scaled_value;
        logic                       result_last;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                invalid;
    } store_entry_t;

    // request from the sequencer to the scaler
    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] value;
        logic                invalid;
        logic [SAMPLE_W-1:0] peak;
        logic [SCALE_W-1:0]  scale;
    } scale_req_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_READ,
        ST_START,
        ST_BUSY,
        ST_EMIT
    } core_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL,
        SC_PREP,
        SC_DIV,
        SC_DONE
    } scaler_state_t;

endpackage

>>> hdl/pns_frame_store.sv
// sample memory of one frame: one write port, one registered read port
// depends on pns_pkg for the entry type
`timescale 1ns / 1ps
module pns_frame_store #(
    parameter int DEPTH = pns_pkg::DEFAULT_FRAME_POINTS,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  pns_pkg::store_entry_t wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output pns_pkg::store_entry_t rd_data
);

    pns_pkg::store_entry_t mem [DEPTH];
    pns_pkg::store_entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/pns_scaler.sv
// bit-serial scaler: |sample| * scale by shift-add, then rounded restoring divide by peak
// depends on pns_pkg for widths, request type and state encoding
`timescale 1ns / 1ps
module pns_scaler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pns_pkg::scale_req_t                  req,
    output logic                                 done,
    output logic signed [pns_pkg::RESULT_W-1:0]  scaled_value
);

    localparam int SW = pns_pkg::SAMPLE_W;
    localparam int CW = pns_pkg::SCALE_W;
    localparam int PW = pns_pkg::PROD_W;
    localparam int NW = pns_pkg::NUM_W;
    localparam int DW = pns_pkg::DIV_W;
    localparam int QW = pns_pkg::QUOT_W;
    localparam int TW = pns_pkg::STEP_W;

    pns_pkg::scaler_state_t state_reg, state_next;
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] mag_reg, mag_next;
    logic [CW-1:0] scale_sh_reg, scale_sh_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [SW-1:0] peak_reg, peak_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [QW-1:0] quot_reg, quot_next;
    logic          neg_reg, neg_next;
    logic          zero_reg, zero_next;

    logic [NW-1:0] numer;
    logic [DW-1:0] divisor;
    logic [DW:0]   trial;
    logic [DW:0]   trial_diff;
    logic [SW-1:0] req_mag;

    // magnitude of the requested sample, most negative value fits unsigned
    assign req_mag = req.value[SW-1] ? (~req.value + SW'(1)) : req.value;

    // rounded dividend 2*num + den and divisor 2*den
    assign numer   = {acc_reg, 1'b0} + NW'(peak_reg);
    assign divisor = {peak_reg, 1'b0};
    assign trial      = {rem_reg, low_reg[QW-1]};
    assign trial_diff = trial - {1'b0, divisor};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pns_pkg::SC_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        scale_sh_reg <= scale_sh_next;
        acc_reg      <= acc_next;
        peak_reg     <= peak_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        quot_reg     <= quot_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
    end

    // sequencing of multiply and divide steps
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mag_next      = mag_reg;
        scale_sh_next = scale_sh_reg;
        acc_next      = acc_reg;
        peak_next     = peak_reg;
        rem_next      = rem_reg;
        low_next      = low_reg;
        quot_next     = quot_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        done          = 1'b0;
        case (state_reg)
            pns_pkg::SC_IDLE: begin
                if (req.start) begin
                    mag_next      = req_mag;
                    scale_sh_next = req.scale;
                    peak_next     = req.peak;
                    neg_next      = req.value[SW-1];
                    zero_next     = req.invalid || (req.peak == '0);
                    acc_next      = '0;
                    cnt_next      = TW'(CW - 1);
                    state_next    = pns_pkg::SC_MUL;
                end
            end
            pns_pkg::SC_MUL: begin
                // one scale bit per cycle, msb first
                acc_next = {acc_reg[PW-2:0], 1'b0}
                           + (scale_sh_reg[CW-1] ? PW'(mag_reg) : PW'(0));
                scale_sh_next = {scale_sh_reg[CW-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    state_next = pns_pkg::SC_PREP;
                end else begin
                    cnt_next = cnt_reg - TW'(1);
                end
            end
            pns_pkg::SC_PREP: begin
                // quotient is below 2^QW, so the top bits start below the divisor
                rem_next   = DW'(numer[NW-1:QW]);
                low_next   = numer[QW-1:0];
                quot_next  = '0;
                cnt_next   = TW'(QW - 1);
                state_next = pns_pkg::SC_DIV;
            end
            pns_pkg::SC_DIV: begin
                // one quotient bit per cycle
                if (!trial_diff[DW]) begin
                    rem_next  = trial_diff[DW-1:0];
                    quot_next = {quot_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next  = trial[DW-1:0];
                    quot_next = {quot_reg[QW-2:0], 1'b0};
                end
                low_next = {low_reg[QW-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    state_next = pns_pkg::SC_DONE;
                end else begin
                    cnt_next = cnt_reg - TW'(1);
                end
            end
            pns_pkg::SC_DONE: begin
                done       = 1'b1;
                state_next = pns_pkg::SC_IDLE;
            end
            default: begin
                state_next = pns_pkg::SC_IDLE;
            end
        endcase
    end

    // sign and zero cases applied to the held quotient
    assign scaled_value = zero_reg ? '0
                        : (neg_reg ? $signed(~quot_reg + QW'(1)) : $signed(quot_reg));

endmodule

>>> hdl/peak_normalize_scale_core.sv
// peak normalization core: the frame samples are stored, the peak magnitude is
// tracked, and on the last sample every stored sample is emitted scaled to the peak.
//
// input channel s_valid/s_ready/s_data carries one sample per transfer; the
// channel is ready only while a frame is being collected, one sample per cycle.
// a frame ends on frame_last or on its FRAME_POINTS-th sample; the channel then
// stays low until the last result of that frame has been loaded for output.
// result channel m_valid/m_ready/m_data carries one scaled sample per transfer,
// in arrival order, with result_last on the final one.
// each result passes through a memory read, a start step, a shift-add multiply
// by output_scale, one setup step, a restoring divide by twice the peak, a done
// step and a load into the output register; the multiply and divide in the
// scaler are bit-serial.
// a stalled receiver holds the output register; the next result waits in the
// scaler and the sequencer stops until the register is free.
// reset (aresetn low at a clock edge) empties the frame, clears the peak, drops
// m_valid and sets output_scale to 10. output_scale is written over the APB port.
`timescale 1ns / 1ps
`include "peak_normalize_scale_core_assert.svh"
module peak_normalize_scale_core #(
    parameter int FRAME_POINTS = pns_pkg::DEFAULT_FRAME_POINTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pns_pkg::in_item_t                   s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output pns_pkg::out_item_t                  m_data,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pns_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pns_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pns_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IDX_W = (FRAME_POINTS > 1) ? $clog2(FRAME_POINTS) : 1;
    localparam int CNT_W = $clog2(FRAME_POINTS + 1);
    localparam int SW    = pns_pkg::SAMPLE_W;
    localparam int CW    = pns_pkg::SCALE_W;
    localparam int AW    = pns_pkg::APB_ADDR_W;
    localparam int DTW   = pns_pkg::APB_DATA_W;

    pns_pkg::core_state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [SW-1:0]    peak_reg, peak_next;
    logic [CW-1:0]    scale_reg, scale_next;
    logic             out_valid_reg, out_valid_next;
    pns_pkg::out_item_t out_reg, out_next;

    logic             in_xfer;
    logic             out_load;
    logic             frame_end;
    logic             item_last;
    logic [CNT_W-1:0] fill_inc;
    logic [SW-1:0]    in_mag;
    logic             cfg_write;

    pns_pkg::store_entry_t wr_entry;
    pns_pkg::store_entry_t rd_entry;
    pns_pkg::scale_req_t   req;
    logic                  scaler_done;
    logic signed [pns_pkg::RESULT_W-1:0] scaler_value;

    // handshakes
    assign s_ready  = (state_reg == pns_pkg::ST_COLLECT);
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // frame bookkeeping
    assign fill_inc  = fill_reg + CNT_W'(1);
    assign frame_end = s_data.frame_last || (fill_inc == CNT_W'(FRAME_POINTS));
    assign item_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == fill_reg);
    assign in_mag    = s_data.sample_value[SW-1] ? (~s_data.sample_value + SW'(1))
                                                 : s_data.sample_value;

    assign wr_entry.value   = s_data.sample_value;
    assign wr_entry.invalid = s_data.sample_invalid;

    // sample memory
    pns_frame_store #(
        .DEPTH (FRAME_POINTS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_xfer),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_entry)
    );

    // scaler request
    assign req.start   = (state_reg == pns_pkg::ST_START);
    assign req.value   = rd_entry.value;
    assign req.invalid = rd_entry.invalid;
    assign req.peak    = peak_reg;
    assign req.scale   = scale_reg;

    pns_scaler u_scaler (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (req),
        .done         (scaler_done),
        .scaled_value (scaler_value)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[AW-1:2] == pns_pkg::REG_OUTPUT_SCALE);
    assign prdata    = (paddr[AW-1:2] == pns_pkg::REG_OUTPUT_SCALE)
                       ? DTW'(scale_reg) : '0;

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pns_pkg::ST_COLLECT;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            peak_reg      <= '0;
            scale_reg     <= pns_pkg::OUTPUT_SCALE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            peak_reg      <= peak_next;
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // sequencer: collect, then read, scale and emit each stored sample
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        peak_next      = peak_reg;
        scale_next     = cfg_write ? pwdata[CW-1:0] : scale_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        out_valid_next = (out_valid_reg && !m_ready);
        case (state_reg)
            pns_pkg::ST_COLLECT: begin
                if (in_xfer) begin
                    fill_next = fill_inc;
                    if (!s_data.sample_invalid && (in_mag > peak_reg)) begin
                        peak_next = in_mag;
                    end
                    if (frame_end) begin
                        rd_idx_next = '0;
                        state_next  = pns_pkg::ST_READ;
                    end
                end
            end
            pns_pkg::ST_READ: begin
                state_next = pns_pkg::ST_START;
            end
            pns_pkg::ST_START: begin
                state_next = pns_pkg::ST_BUSY;
            end
            pns_pkg::ST_BUSY: begin
                if (scaler_done) begin
                    state_next = pns_pkg::ST_EMIT;
                end
            end
            pns_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load              = 1'b1;
                    out_valid_next        = 1'b1;
                    out_next.scaled_value = scaler_value;
                    out_next.result_last  = item_last;
                    if (item_last) begin
                        fill_next  = '0;
                        peak_next  = '0;
                        state_next = pns_pkg::ST_COLLECT;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = pns_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = pns_pkg::ST_COLLECT;
            end
        endcase
    end

    // checks
    `PNS_ASSERT_NEXT(a_frame_end_stops_input, aclk, aresetn, in_xfer && s_data.frame_last, !s_ready)
    `PNS_ASSERT_NOW(a_no_overwrite, aclk, aresetn, out_load, !out_valid_reg || m_ready)
    `PNS_ASSERT_NOW(a_done_only_when_busy, aclk, aresetn, scaler_done, state_reg == pns_pkg::ST_BUSY)
    `PNS_ASSERT_NOW(a_fill_bounded, aclk, aresetn, s_ready, fill_reg < CNT_W'(FRAME_POINTS))

endmodule
